// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared payload types, character and register codes, and the command and
// status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned COLOUR_W = 8;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned CELL_W   = CHAR_W + COLOUR_W;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHR_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CHR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHR_BACKSPACE = 8'h08;

  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  localparam logic [NIBBLE_W-1:0] FG_RESET = 4'hF;
  localparam logic [NIBBLE_W-1:0] BG_RESET = 4'h0;
  localparam logic [CELL_W-1:0]   CELL_RESET = 16'h0F20;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] read_index;
  } tcw_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0]   cell_char;
    logic [COLOUR_W-1:0] cell_colour;
  } tcw_out_t;

  typedef enum logic [1:0] {
    WA_CUR,
    WA_CUR_M1,
    WA_WALK,
    WA_WALK_UP
  } waddr_sel_e;

  typedef enum logic [1:0] {
    WD_CHAR,
    WD_SPACE,
    WD_RESET,
    WD_RDATA
  } wdata_sel_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_BACK,
    CUR_DOWN,
    CUR_HOME
  } cur_op_e;

  typedef enum logic [2:0] {
    WALK_HOLD,
    WALK_INC,
    WALK_ZERO,
    WALK_ROW1,
    WALK_LAST
  } walk_op_e;

  typedef struct packed {
    logic       latch;
    logic       we;
    waddr_sel_e waddr_sel;
    wdata_sel_e wdata_sel;
    logic       rd_index;
    cur_op_e    cur_op;
    walk_op_e   walk_op;
    logic       cell_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              is_nl;
    logic              is_bs;
    logic              col_zero;
    logic              col_full;
    logic              last_row;
    logic              walk_last;
    logic              idx_ok;
  } tcw_stat_t;

endpackage

// File: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// State machine that sequences the cell writes, scrolls, fills and reads
// carried out by the datapath.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      done_o,
  input  tcw_stat_t stat_i,
  output tcw_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_EXEC    = 3'd2;
  localparam logic [2:0] S_PUT     = 3'd3;
  localparam logic [2:0] S_SCR_RD  = 3'd4;
  localparam logic [2:0] S_SCR_WR  = 3'd5;
  localparam logic [2:0] S_FILL    = 3'd6;
  localparam logic [2:0] S_RD_WAIT = 3'd7;

  logic [2:0] state_q, state_d;
  logic       pend_q, pend_d;
  logic       done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    pend_d  = pend_q;
    done_d  = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.we        = 1'b1;
        cmd_o.waddr_sel = WA_WALK;
        cmd_o.wdata_sel = WD_RESET;
        if (stat_i.walk_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.walk_op = WALK_INC;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.func)
          FUNC_PUT: begin
            if (stat_i.is_nl) begin
              if (stat_i.last_row) begin
                cmd_o.cur_op  = CUR_HOME;
                cmd_o.walk_op = WALK_ROW1;
                pend_d        = 1'b0;
                state_d       = S_SCR_RD;
              end else begin
                cmd_o.cur_op = CUR_DOWN;
                done_d       = 1'b1;
                state_d      = S_IDLE;
              end
            end else if (stat_i.is_bs) begin
              if (!stat_i.col_zero) begin
                cmd_o.we        = 1'b1;
                cmd_o.waddr_sel = WA_CUR_M1;
                cmd_o.wdata_sel = WD_SPACE;
                cmd_o.cur_op    = CUR_BACK;
              end
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (stat_i.col_full) begin
              if (stat_i.last_row) begin
                cmd_o.cur_op  = CUR_HOME;
                cmd_o.walk_op = WALK_ROW1;
                pend_d        = 1'b1;
                state_d       = S_SCR_RD;
              end else begin
                cmd_o.cur_op = CUR_DOWN;
                state_d      = S_PUT;
              end
            end else begin
              cmd_o.we        = 1'b1;
              cmd_o.waddr_sel = WA_CUR;
              cmd_o.wdata_sel = WD_CHAR;
              cmd_o.cur_op    = CUR_ADV;
              done_d          = 1'b1;
              state_d         = S_IDLE;
            end
          end
          FUNC_CLEAR: begin
            cmd_o.walk_op = WALK_ZERO;
            pend_d        = 1'b0;
            state_d       = S_FILL;
          end
          FUNC_READ: begin
            if (stat_i.idx_ok) begin
              cmd_o.rd_index = 1'b1;
              state_d        = S_RD_WAIT;
            end else begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_PUT: begin
        cmd_o.we        = 1'b1;
        cmd_o.waddr_sel = WA_CUR;
        cmd_o.wdata_sel = WD_CHAR;
        cmd_o.cur_op    = CUR_ADV;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end
      S_SCR_RD: begin
        state_d = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd_o.we        = 1'b1;
        cmd_o.waddr_sel = WA_WALK_UP;
        cmd_o.wdata_sel = WD_RDATA;
        if (stat_i.walk_last) begin
          cmd_o.walk_op = WALK_LAST;
          state_d       = S_FILL;
        end else begin
          cmd_o.walk_op = WALK_INC;
          state_d       = S_SCR_RD;
        end
      end
      S_FILL: begin
        cmd_o.we        = 1'b1;
        cmd_o.waddr_sel = WA_WALK;
        cmd_o.wdata_sel = WD_SPACE;
        if (stat_i.walk_last) begin
          if (pend_q) begin
            pend_d  = 1'b0;
            state_d = S_PUT;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.walk_op = WALK_INC;
        end
      end
      S_RD_WAIT: begin
        cmd_o.cell_load = 1'b1;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen cell memory, cursor registers, sweep counter, colour registers and
// the result register.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [NIBBLE_W-1:0]  cfg_data_i,
  input  tcw_in_t              item_i,
  input  tcw_cmd_t             cmd_i,
  output tcw_stat_t            stat_o,
  output tcw_out_t             result_o
);

  localparam int unsigned CELLS  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned POS_W  = $clog2(CELLS + 1);
  localparam int unsigned COL_W  = $clog2(COLUMNS + 1);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned EXT_W  = POS_W + INDEX_W;

  logic [CELL_W-1:0]   mem_q [CELLS];
  logic [CELL_W-1:0]   rdata_q;
  logic [CELL_W-1:0]   cell_q;
  tcw_in_t             item_q;
  logic [NIBBLE_W-1:0] fg_q, bg_q;
  logic [ROW_W-1:0]    row_q;
  logic [POS_W-1:0]    base_q;
  logic [COL_W-1:0]    col_q;
  logic [ADDR_W-1:0]   walk_q;

  logic [POS_W-1:0]    pos;
  logic [EXT_W-1:0]    pos_ext;
  logic [COLOUR_W-1:0] colour;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [CELL_W-1:0]   wdata;

  assign pos     = base_q + POS_W'(col_q);
  assign pos_ext = EXT_W'(pos);
  assign colour  = {bg_q, fg_q};

  always_comb begin
    case (cmd_i.waddr_sel)
      WA_CUR:     waddr = ADDR_W'(pos);
      WA_CUR_M1:  waddr = ADDR_W'(pos - POS_W'(1));
      WA_WALK:    waddr = walk_q;
      WA_WALK_UP: waddr = walk_q - ADDR_W'(COLUMNS);
      default:    waddr = walk_q;
    endcase
    case (cmd_i.wdata_sel)
      WD_CHAR:  wdata = {colour, item_q.ch};
      WD_SPACE: wdata = {colour, CHR_SPACE};
      WD_RESET: wdata = CELL_RESET;
      WD_RDATA: wdata = rdata_q;
      default:  wdata = CELL_RESET;
    endcase
    raddr = cmd_i.rd_index ? ADDR_W'(item_q.read_index) : walk_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
      cell_q <= '0;
    end else if (cmd_i.cell_load) begin
      cell_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_FG) begin
        fg_q <= cfg_data_i;
      end else begin
        bg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      base_q <= '0;
      col_q  <= '0;
    end else begin
      case (cmd_i.cur_op)
        CUR_ADV:  col_q <= col_q + COL_W'(1);
        CUR_BACK: col_q <= col_q - COL_W'(1);
        CUR_DOWN: begin
          row_q  <= row_q + ROW_W'(1);
          base_q <= base_q + POS_W'(COLUMNS);
          col_q  <= '0;
        end
        CUR_HOME: col_q <= '0;
        default:  col_q <= col_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else begin
      case (cmd_i.walk_op)
        WALK_INC:  walk_q <= walk_q + ADDR_W'(1);
        WALK_ZERO: walk_q <= '0;
        WALK_ROW1: walk_q <= ADDR_W'(COLUMNS);
        WALK_LAST: walk_q <= ADDR_W'(CELLS - COLUMNS);
        default:   walk_q <= walk_q;
      endcase
    end
  end

  assign stat_o.func      = item_q.func;
  assign stat_o.is_nl     = (item_q.ch == CHR_NEWLINE);
  assign stat_o.is_bs     = (item_q.ch == CHR_BACKSPACE);
  assign stat_o.col_zero  = (col_q == '0);
  assign stat_o.col_full  = (col_q == COL_W'(COLUMNS));
  assign stat_o.last_row  = (row_q == ROW_W'(ROWS - 1));
  assign stat_o.walk_last = (walk_q == ADDR_W'(CELLS - 1));
  assign stat_o.idx_ok    = (32'(item_q.read_index) < CELLS);

  assign result_o.cursor_pos  = pos_ext[INDEX_W-1:0];
  assign result_o.cell_char   = cell_q[CHAR_W-1:0];
  assign result_o.cell_colour = cell_q[CELL_W-1:CHAR_W];

endmodule

// File: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console over a ROWS x COLUMNS store of character and colour cells.
//
// A command is taken at a rising edge with start high and busy low. Its
// result appears on result_o for one cycle with done_o high, and busy is low
// in that cycle, so the next command can be taken at the edge ending it.
// The receiver cannot hold results back.
// An ordinary character, backspace, newline without scroll or unused code
// finishes in S_EXEC; a wrap adds S_PUT and a read adds S_RD_WAIT. A scroll
// copies every row but the first up one row, fills the last row with spaces
// and then writes a wrapped character if one is pending; a clear fills every
// cell with spaces. The cell memory has one write port and one registered
// read port: a scroll moves one cell per read and write state pair, a fill
// writes one cell per cycle. After reset busy stays high while the memory is
// filled with white-on-black spaces. Colour registers are written through
// the configuration port with no wait; the user must do so only while no
// transaction is in progress, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tcw_in_t              item_i,
  output logic                 done_o,
  output tcw_out_t             result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [NIBBLE_W-1:0]  cfg_data_i
);

  localparam int unsigned CELLS = ROWS * COLUMNS;

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("Result strobe while a transaction is still in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("Accepted transaction did not raise busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("Result strobe lasted more than one cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(result_o.cursor_pos) <= CELLS))
    else $error("Cursor position beyond the screen.");

endmodule

// File: tb/sv/tb_console_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench package
// Screen constants and the scoreboard. The scoreboard keeps its own copy of
// the cell store, the cursor and the colour registers. It works out the
// expected result of every accepted transaction and checks the results in
// order.
// ----------------------------------------------------------------------------
package tb_console_pkg;

  import tcw_pkg::*;

  localparam int unsigned SCREEN_COLS  = 80;
  localparam int unsigned SCREEN_ROWS  = 25;
  localparam int unsigned SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  class console_scoreboard;

    logic [CELL_W-1:0]   cells [SCREEN_CELLS];
    int unsigned         row;
    int unsigned         col;
    logic [NIBBLE_W-1:0] fg;
    logic [NIBBLE_W-1:0] bg;
    tcw_out_t            pending_results [$];
    int unsigned         errors;

    function new();
      fg     = FG_RESET;
      bg     = BG_RESET;
      row    = 0;
      col    = 0;
      errors = 0;
      blank_all();
    endfunction

    function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [NIBBLE_W-1:0] val);
      if (idx == CFG_FG) begin
        fg = val;
      end else begin
        bg = val;
      end
    endfunction

    function logic [CELL_W-1:0] paint(logic [CHAR_W-1:0] c);
      return {bg, fg, c};
    endfunction

    function void blank_all();
      foreach (cells[i]) cells[i] = paint(CHR_SPACE);
    endfunction

    function void line_feed();
      col = 0;
      if (row < SCREEN_ROWS - 1) begin
        row++;
      end else begin
        for (int unsigned i = SCREEN_COLS; i < SCREEN_CELLS; i++) begin
          cells[i - SCREEN_COLS] = cells[i];
        end
        for (int unsigned i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) begin
          cells[i] = paint(CHR_SPACE);
        end
      end
    endfunction

    function int unsigned cursor();
      return row * SCREEN_COLS + col;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void apply_command(tcw_in_t cmd);
      tcw_out_t res;
      res = '0;
      case (cmd.func)
        FUNC_PUT: begin
          if (cmd.ch == CHR_NEWLINE) begin
            line_feed();
          end else if (cmd.ch == CHR_BACKSPACE) begin
            if (col > 0) begin
              col--;
              cells[row * SCREEN_COLS + col] = paint(CHR_SPACE);
            end
          end else begin
            if (col >= SCREEN_COLS) line_feed();
            cells[row * SCREEN_COLS + col] = paint(cmd.ch);
            col++;
          end
        end
        FUNC_CLEAR: begin
          blank_all();
        end
        FUNC_READ: begin
          if (cmd.read_index < SCREEN_CELLS) begin
            res.cell_char   = cells[cmd.read_index][CHAR_W-1:0];
            res.cell_colour = cells[cmd.read_index][CELL_W-1:CHAR_W];
          end
        end
        default: ;
      endcase
      res.cursor_pos = INDEX_W'(cursor());
      pending_results.push_back(res);
    endfunction

    function void check_result(tcw_out_t got);
      tcw_out_t exp;
      if (pending_results.size() == 0) begin
        $error("Result with no transaction pending: cursor_pos %0d, cell_char %0d, cell_colour %0d",
               got.cursor_pos, got.cell_char, got.cell_colour);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.cursor_pos !== exp.cursor_pos) begin
        $error("cursor_pos: expected %0d, actual %0d", exp.cursor_pos, got.cursor_pos);
        errors++;
      end
      if (got.cell_char !== exp.cell_char) begin
        $error("cell_char: expected 0x%02h, actual 0x%02h", exp.cell_char, got.cell_char);
        errors++;
      end
      if (got.cell_colour !== exp.cell_colour) begin
        $error("cell_colour: expected 0x%02h, actual 0x%02h", exp.cell_colour, got.cell_colour);
        errors++;
      end
    endfunction

  endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, newline, backspace, wrap, clear, read and unused commands into
// the console, first a short directed sequence and then four phases of random
// text with different colour settings and sender idling. Every result is
// checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  import tcw_pkg::*;
  import tb_console_pkg::*;

  localparam int unsigned PHASE_ITEMS = 258;
  localparam int unsigned PHASE_IDLE [4] = '{0, 48, 0, 32};
  // Allows every transaction to be a full scroll, several times over.
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  tcw_in_t              item_i;
  logic                 done_o;
  tcw_out_t             result_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [NIBBLE_W-1:0]  cfg_data_i;

  console_scoreboard sb;
  int unsigned       idle_pct;
  int unsigned       phase_items;
  int unsigned       cycle_count = 0;

  text_console_writer #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  function automatic tcw_in_t make_cmd(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c,
                                       logic [INDEX_W-1:0] idx);
    tcw_in_t m;
    m.func       = f;
    m.ch         = c;
    m.read_index = idx;
    return m;
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255));
    while (c == CHR_NEWLINE || c == CHR_BACKSPACE);
    return c;
  endfunction

  task automatic issue(input tcw_in_t cmd);
    int unsigned gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= cmd;
    do @(posedge clk_i);
    while (busy);
    sb.apply_command(cmd);
    phase_items++;
  endtask

  task automatic put(input logic [CHAR_W-1:0] c);
    issue(make_cmd(FUNC_PUT, c, INDEX_W'($urandom_range(2047))));
  endtask

  task automatic read_at(input logic [INDEX_W-1:0] idx);
    issue(make_cmd(FUNC_READ, CHAR_W'($urandom_range(255)), idx));
  endtask

  task automatic clear_screen();
    issue(make_cmd(FUNC_CLEAR, CHAR_W'($urandom_range(255)), INDEX_W'($urandom_range(2047))));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_colours(input logic [NIBBLE_W-1:0] fg, input logic [NIBBLE_W-1:0] bg);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_FG;
    cfg_data_i  <= fg;
    @(posedge clk_i);
    cfg_index_i <= CFG_BG;
    cfg_data_i  <= bg;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_colour(CFG_FG, fg);
    sb.set_colour(CFG_BG, bg);
  endtask

  task automatic random_segment();
    int unsigned kind;
    int unsigned pos;
    int unsigned back;
    kind = $urandom_range(99);
    if (kind < 45) begin
      repeat ($urandom_range(20, 1)) begin
        if ($urandom_range(9) == 0) begin
          put(CHR_BACKSPACE);
        end else begin
          put(plain_char());
        end
      end
      put(CHR_NEWLINE);
    end else if (kind < 50) begin
      repeat ($urandom_range(95, 60)) put(plain_char());
    end else if (kind < 64) begin
      repeat ($urandom_range(6, 1)) put(CHR_BACKSPACE);
    end else if (kind < 86) begin
      repeat ($urandom_range(4, 1)) begin
        if ($urandom_range(3) == 0) begin
          read_at(INDEX_W'($urandom_range(2047)));
        end else begin
          pos  = sb.cursor();
          back = $urandom_range(90);
          read_at(INDEX_W'(pos > back ? pos - back : 0));
        end
      end
    end else if (kind < 91) begin
      clear_screen();
    end else if (kind < 96) begin
      issue(make_cmd(FUNC_UNUSED, CHAR_W'($urandom_range(255)), INDEX_W'($urandom_range(2047))));
    end else begin
      repeat ($urandom_range(3, 1)) put(CHR_NEWLINE);
    end
  endtask

  initial begin
    sb          = new();
    idle_pct    = 0;
    phase_items = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_FG;
    cfg_data_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    read_at(INDEX_W'(0));
    read_at(INDEX_W'(SCREEN_CELLS - 1));
    read_at(INDEX_W'(SCREEN_CELLS));
    read_at(INDEX_W'(2047));
    put(8'h00);
    put(8'hFF);
    put(8'h41);
    put(CHR_BACKSPACE);
    read_at(INDEX_W'(2));
    read_at(INDEX_W'(1));
    issue(make_cmd(FUNC_UNUSED, 8'hFF, INDEX_W'(2047)));
    put(CHR_NEWLINE);
    put(CHR_BACKSPACE);
    put(8'h7F);
    clear_screen();
    read_at(INDEX_W'(0));
    read_at(INDEX_W'(SCREEN_COLS));

    for (int unsigned ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: set_colours(4'h0, 4'hF);
        1: set_colours(4'hF, 4'hF);
        2: set_colours(4'h0, 4'h0);
        default: set_colours(NIBBLE_W'($urandom_range(15)), NIBBLE_W'($urandom_range(15)));
      endcase
      idle_pct    = PHASE_IDLE[ph];
      phase_items = 0;
      if (ph == 0) begin
        // Fill a row to its end, step back from the end, then wrap.
        repeat (SCREEN_COLS - 1) put(plain_char());
        put(CHR_BACKSPACE);
        repeat (3) put(plain_char());
      end
      while (phase_items < PHASE_ITEMS) random_segment();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
